FILE: hdl/keypad_to_mouse_event_translator_top_defines.svh
// Assertion macros shared by the translator RTL.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef KEYPAD_TO_MOUSE_EVENT_TRANSLATOR_TOP_DEFINES_SVH
`define KEYPAD_TO_MOUSE_EVENT_TRANSLATOR_TOP_DEFINES_SVH

// same-cycle implication
`define KMT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/kmt_pkg.sv
// Types, codes, constants and scancode lookup for the keypad-to-mouse translator.
// No dependencies.
package kmt_pkg;

  localparam int SPEED_W   = 7;
  localparam int MAX_SPEED = 127;

  // event types and codes
  localparam logic [4:0] EVT_KEY     = 5'd1;
  localparam logic [4:0] EVT_REL     = 5'd2;
  localparam logic [4:0] EVT_MSC     = 5'd4;
  localparam logic [9:0] SCAN_CODE   = 10'd4;
  localparam logic [9:0] K_ENTER     = 10'd28;
  localparam logic [9:0] K_B         = 10'd48;
  localparam logic [9:0] K_F12       = 10'd88;
  localparam logic [9:0] K_UP        = 10'd103;
  localparam logic [9:0] K_LEFT      = 10'd105;
  localparam logic [9:0] K_RIGHT     = 10'd106;
  localparam logic [9:0] K_DOWN      = 10'd108;
  localparam logic [9:0] K_VOLDOWN   = 10'd114;
  localparam logic [9:0] K_VOLUP     = 10'd115;
  localparam logic [9:0] K_HELP      = 10'd138;
  localparam logic [9:0] K_MENU      = 10'd139;
  localparam logic [9:0] K_SEND      = 10'd231;
  localparam logic [9:0] BUTTON_LEFT = 10'd272;
  localparam logic [9:0] AXIS_X      = 10'd0;
  localparam logic [9:0] AXIS_Y      = 10'd1;
  localparam logic [9:0] AXIS_WHEEL  = 10'd8;

  localparam int MAP_N = 7;

  typedef enum logic [1:0] {
    CMD_EVENT   = 2'd0,
    CMD_ENABLE  = 2'd1,
    CMD_DISABLE = 2'd2,
    CMD_TOGGLE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ROUTE_DROP        = 2'd0,
    ROUTE_KEY_PASS    = 2'd1,
    ROUTE_KEY_REWRITE = 2'd2,
    ROUTE_MOUSE       = 2'd3
  } route_e;

  typedef enum logic [1:0] {
    REG_KEYMAP_SELECT = 2'd0,
    REG_HOLD_LIMIT    = 2'd1,
    REG_WHEEL_DIVIDER = 2'd2,
    REG_MIN_SPEED     = 2'd3
  } reg_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [4:0]         ev_type;
    logic [9:0]         ev_code;
    logic signed [31:0] ev_value;
    logic [31:0]        ev_seconds;
  } item_t;

  typedef struct packed {
    route_e               route;
    logic [4:0]           out_type;
    logic [9:0]           out_code;
    logic signed [31:0]   out_value;
    logic                 mouse_enabled;
    logic [SPEED_W-1:0]   speed_now;
    logic                 drag_now;
  } res_t;

  typedef struct packed {
    logic               mode_enabled;
    logic [31:0]        press_time;
    logic [SPEED_W-1:0] step_size;
    logic               drag_flag;
    logic [7:0]         wheel_count;
  } state_t;

  typedef struct packed {
    logic               keymap_select;
    logic [7:0]         hold_limit_seconds;
    logic [7:0]         wheel_divider;
    logic [SPEED_W-1:0] minimum_speed;
  } cfg_t;

  typedef struct packed {
    logic       hit;
    logic [9:0] key;
  } scan_hit_t;

  localparam state_t STATE_RESET = '{
    mode_enabled: 1'b0,
    press_time:   32'd0,
    step_size:    7'd4,
    drag_flag:    1'b0,
    wheel_count:  8'd0
  };

  localparam cfg_t CFG_RESET = '{
    keymap_select:      1'b0,
    hold_limit_seconds: 8'd1,
    wheel_divider:      8'd5,
    minimum_speed:      7'd1
  };

  // key per map slot, shared by both scancode maps
  function automatic logic [9:0] map_key(input int unsigned i);
    logic [9:0] k;
    k = K_HELP;
    unique case (i)
      0: k = K_UP;
      1: k = K_DOWN;
      2: k = K_LEFT;
      3: k = K_RIGHT;
      4: k = K_MENU;
      5: k = K_SEND;
      default: k = K_HELP;
    endcase
    return k;
  endfunction

  // scancode per map slot: keypad map (sel 0) or laptop map (sel 1)
  function automatic logic [7:0] map_scan(input logic sel, input int unsigned i);
    logic [7:0] s;
    s = 8'd0;
    if (!sel) begin
      unique case (i)
        0: s = 8'd35;
        1: s = 8'd9;
        2: s = 8'd19;
        3: s = 8'd34;
        4: s = 8'd33;
        5: s = 8'd2;
        default: s = 8'd42;
      endcase
    end else begin
      unique case (i)
        0: s = 8'd200;
        1: s = 8'd208;
        2: s = 8'd203;
        3: s = 8'd205;
        4: s = 8'd17;
        5: s = 8'd31;
        default: s = 8'd88;
      endcase
    end
    return s;
  endfunction

  // first matching slot wins (scancodes in one map are distinct anyway)
  function automatic scan_hit_t scan_lookup(input logic sel, input logic [31:0] scan);
    scan_hit_t r;
    r = '{hit: 1'b0, key: 10'd0};
    for (int i = MAP_N - 1; i >= 0; i--) begin
      if (scan == {24'd0, map_scan(sel, i)}) begin
        r.hit = 1'b1;
        r.key = map_key(i);
      end
    end
    return r;
  endfunction

  function automatic logic key_in_map(input logic [9:0] key);
    logic f;
    f = 1'b0;
    for (int i = 0; i < MAP_N; i++) begin
      if (key == map_key(i)) f = 1'b1;
    end
    return f;
  endfunction

endpackage

FILE: hdl/kmt_if.sv
// Channel interfaces of the translator: input items, results, register writes.
// Depends on kmt_pkg.
interface kmt_in_if;
  import kmt_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [4:0]         ev_type;
  logic [9:0]         ev_code;
  logic signed [31:0] ev_value;
  logic [31:0]        ev_seconds;

  modport source (output valid, cmd, ev_type, ev_code, ev_value, ev_seconds, input ready);
  modport sink   (input valid, cmd, ev_type, ev_code, ev_value, ev_seconds, output ready);
endinterface

interface kmt_out_if;
  import kmt_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         route;
  logic [4:0]         out_type;
  logic [9:0]         out_code;
  logic signed [31:0] out_value;
  logic               mouse_enabled;
  logic [SPEED_W-1:0] speed_now;
  logic               drag_now;

  modport source (output valid, route, out_type, out_code, out_value, mouse_enabled,
                  speed_now, drag_now, input ready);
  modport sink   (input valid, route, out_type, out_code, out_value, mouse_enabled,
                  speed_now, drag_now, output ready);
endinterface

interface kmt_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] reg_index;
  logic [7:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

FILE: hdl/kmt_xlate.sv
// Single-pass translation of one item: routed event, status and next state.
// Depends on kmt_pkg.
module kmt_xlate (
  input  kmt_pkg::item_t  item,
  input  kmt_pkg::cfg_t   cfg,
  input  kmt_pkg::state_t st,
  output kmt_pkg::state_t st_nxt,
  output kmt_pkg::res_t   res
);
  import kmt_pkg::*;

  scan_hit_t          scan;
  logic               is_scan;
  logic [31:0]        held;
  logic               held_gt;
  logic               held_lt;
  logic               key_ok;
  logic [9:0]         key;
  logic               muted;
  logic               is_toggle_key;
  logic [7:0]         wdiv;
  logic [8:0]         wc_inc;
  logic               wheel_emit;
  logic [7:0]         wc_nxt;
  logic [SPEED_W:0]   spd_inc;
  logic [SPEED_W-1:0] spd_up;
  logic [SPEED_W-1:0] spd_lo;
  logic [SPEED_W-1:0] spd_dec;
  logic [SPEED_W-1:0] spd_down;

  // scancode lookup and hold time
  assign scan    = scan_lookup(cfg.keymap_select, item.ev_value);
  assign is_scan = (item.ev_type == EVT_MSC) && (item.ev_code == SCAN_CODE);
  assign held    = (st.press_time == 32'd0) ? 32'd0 : item.ev_seconds - st.press_time;
  assign held_gt = $signed(held) > $signed({24'd0, cfg.hold_limit_seconds});
  assign held_lt = $signed(held) < $signed({24'd0, cfg.hold_limit_seconds});
  assign is_toggle_key = (item.ev_type == EVT_KEY)
                      && ((item.ev_code == K_HELP) || (item.ev_code == K_F12));

  // key seen in mouse mode
  assign key_ok = is_scan ? scan.hit : 1'b1;
  assign key    = is_scan ? scan.key : item.ev_code;
  assign muted  = (item.ev_type == EVT_KEY) && key_in_map(item.ev_code);

  // wheel divider counter
  assign wdiv       = (cfg.wheel_divider == 8'd0) ? 8'd1 : cfg.wheel_divider;
  assign wheel_emit = (st.wheel_count == 8'd0);
  assign wc_inc     = {1'b0, st.wheel_count} + 9'd1;
  assign wc_nxt     = ((st.wheel_count >= wdiv) || (wc_inc >= {1'b0, wdiv}))
                    ? 8'd0 : wc_inc[7:0];

  // speed up (saturating) and down (floored)
  assign spd_inc  = {1'b0, st.step_size} + 8'd1;
  assign spd_up   = (spd_inc > 8'(MAX_SPEED)) ? SPEED_W'(MAX_SPEED) : spd_inc[SPEED_W-1:0];
  assign spd_lo   = (cfg.minimum_speed == '0) ? SPEED_W'(1) : cfg.minimum_speed;
  assign spd_dec  = (st.step_size == '0) ? '0 : st.step_size - SPEED_W'(1);
  assign spd_down = (spd_dec < spd_lo) ? spd_lo : spd_dec;

  // routing decision
  always_comb begin
    st_nxt            = st;
    res.route         = ROUTE_KEY_PASS;
    res.out_type      = item.ev_type;
    res.out_code      = item.ev_code;
    res.out_value     = item.ev_value;

    unique case (item.cmd)
      CMD_ENABLE: begin
        st_nxt.mode_enabled = 1'b1;
        res.route = ROUTE_DROP;
      end
      CMD_DISABLE: begin
        st_nxt.mode_enabled = 1'b0;
        res.route = ROUTE_DROP;
      end
      CMD_TOGGLE: begin
        st_nxt.mode_enabled = ~st.mode_enabled;
        res.route = ROUTE_DROP;
      end
      CMD_EVENT: begin
        priority if (is_scan && scan.hit && (scan.key == K_HELP) && held_gt) begin
          // long hold of the toggle key: replay as a key press/release
          if ($signed(st.press_time) > 32'sd1) begin
            st_nxt.press_time = 32'd1;
            res.route     = ROUTE_KEY_REWRITE;
            res.out_type  = EVT_KEY;
            res.out_code  = scan.key;
            res.out_value = 32'sd1;
          end else if (st.press_time == 32'd1) begin
            st_nxt.press_time = 32'd0;
            res.route     = ROUTE_KEY_REWRITE;
            res.out_type  = EVT_KEY;
            res.out_code  = scan.key;
            res.out_value = 32'sd0;
          end else begin
            res.route = ROUTE_DROP;
          end
        end else if (is_toggle_key) begin
          // toggle key press and release
          if (item.ev_value == 32'sd1) begin
            st_nxt.press_time = item.ev_seconds;
            res.route = ROUTE_MOUSE;
          end else if ((item.ev_value == 32'sd0) && (st.press_time != 32'd0)) begin
            if (held_lt) begin
              st_nxt.mode_enabled = ~st.mode_enabled;
              st_nxt.press_time   = 32'd0;
            end
            res.route = ROUTE_MOUSE;
          end else begin
            res.route = ROUTE_DROP;
          end
        end else if (st.mode_enabled) begin
          // mouse mode key handling
          priority if (muted) begin
            res.route = ROUTE_DROP;
          end else if (key_ok && (key == K_VOLUP)) begin
            if (item.ev_value == 32'sd1) st_nxt.step_size = spd_up;
            res.route = ROUTE_DROP;
          end else if (key_ok && (key == K_VOLDOWN)) begin
            if (item.ev_value == 32'sd1) st_nxt.step_size = spd_down;
            res.route = ROUTE_DROP;
          end else if (key_ok && (key == K_ENTER)) begin
            res.route    = ROUTE_MOUSE;
            res.out_type = EVT_KEY;
            res.out_code = BUTTON_LEFT;
          end else if (key_ok && (key == K_B)) begin
            if (item.ev_value == 32'sd1) begin
              st_nxt.drag_flag = ~st.drag_flag;
              res.route     = ROUTE_MOUSE;
              res.out_type  = EVT_KEY;
              res.out_code  = BUTTON_LEFT;
              res.out_value = {31'd0, ~st.drag_flag};
            end
          end else if (key_ok && ((key == K_UP) || (key == K_DOWN)
                                  || (key == K_LEFT) || (key == K_RIGHT))) begin
            res.route     = ROUTE_MOUSE;
            res.out_type  = EVT_REL;
            res.out_code  = ((key == K_UP) || (key == K_DOWN)) ? AXIS_Y : AXIS_X;
            res.out_value = ((key == K_UP) || (key == K_LEFT))
                          ? 32'd0 - 32'(st.step_size) : 32'(st.step_size);
          end else if (key_ok && ((key == K_MENU) || (key == K_SEND))) begin
            st_nxt.wheel_count = wc_nxt;
            if (wheel_emit) begin
              res.route     = ROUTE_MOUSE;
              res.out_type  = EVT_REL;
              res.out_code  = AXIS_WHEEL;
              res.out_value = (key == K_MENU) ? 32'sd1 : -32'sd1;
            end else begin
              res.route = ROUTE_DROP;
            end
          end else begin
            res.route = ROUTE_KEY_PASS;
          end
        end else begin
          // mouse mode off: pass unchanged
          res.route = ROUTE_KEY_PASS;
        end
      end
      default: res.route = ROUTE_DROP;
    endcase

    // dropped items carry no event
    if (res.route == ROUTE_DROP) begin
      res.out_type  = '0;
      res.out_code  = '0;
      res.out_value = '0;
    end

    res.mouse_enabled = st_nxt.mode_enabled;
    res.speed_now     = st_nxt.step_size;
    res.drag_now      = st_nxt.drag_flag;
  end

endmodule

FILE: hdl/keypad_to_mouse_event_translator_top.sv
// Top level of the keypad-to-mouse event translator: channel handshakes,
// configuration registers, input and result registers. Depends on kmt_pkg, kmt_if, kmt_xlate.
`include "keypad_to_mouse_event_translator_top_defines.svh"

// Takes one item per clock while the result channel is not stalled, and returns
// exactly one result per item: the item is captured in an input register, goes
// through one translation pass (scancode lookup, hold-time compare, speed and wheel
// counter update) and is written into a result register once that register is free.
// Input ready drops only while both the input register and a stalled result register
// are full.
// The configuration port is always ready; write registers only while idle.
module keypad_to_mouse_event_translator_top (
  input  logic       clk,
  input  logic       rst_n,
  kmt_in_if.sink     in_ch,
  kmt_out_if.source  out_ch,
  kmt_cfg_if.sink    cfg_ch
);
  import kmt_pkg::*;

  logic   s1_valid_r;
  item_t  s1_item_r;
  logic   out_valid_r;
  res_t   out_res_r;
  res_t   res_nxt;
  state_t state_r;
  state_t state_nxt;
  cfg_t   cfg_r;
  logic   s1_adv;
  logic   in_xfer;

  // handshake
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // translation pass
  kmt_xlate u_xlate (
    .item   (s1_item_r),
    .cfg    (cfg_r),
    .st     (state_r),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  // control, state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_RESET;
      cfg_r       <= CFG_RESET;
    end else begin
      if (in_xfer) s1_valid_r <= 1'b1;
      else if (s1_adv) s1_valid_r <= 1'b0;

      if (s1_adv) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;

      if (s1_adv) state_r <= state_nxt;

      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (reg_e'(cfg_ch.reg_index))
          REG_KEYMAP_SELECT: cfg_r.keymap_select      <= cfg_ch.wdata[0];
          REG_HOLD_LIMIT:    cfg_r.hold_limit_seconds <= cfg_ch.wdata;
          REG_WHEEL_DIVIDER: cfg_r.wheel_divider      <= cfg_ch.wdata;
          REG_MIN_SPEED:     cfg_r.minimum_speed      <= cfg_ch.wdata[SPEED_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r.cmd        <= cmd_e'(in_ch.cmd);
      s1_item_r.ev_type    <= in_ch.ev_type;
      s1_item_r.ev_code    <= in_ch.ev_code;
      s1_item_r.ev_value   <= in_ch.ev_value;
      s1_item_r.ev_seconds <= in_ch.ev_seconds;
    end
    if (s1_adv) out_res_r <= res_nxt;
  end

  // result channel
  assign out_ch.valid         = out_valid_r;
  assign out_ch.route         = out_res_r.route;
  assign out_ch.out_type      = out_res_r.out_type;
  assign out_ch.out_code      = out_res_r.out_code;
  assign out_ch.out_value     = out_res_r.out_value;
  assign out_ch.mouse_enabled = out_res_r.mouse_enabled;
  assign out_ch.speed_now     = out_res_r.speed_now;
  assign out_ch.drag_now      = out_res_r.drag_now;

  // checks
  `KMT_ASSERT_NEXT(a_state_holds, !s1_adv, $stable(state_r), "state moved without a transfer")
  `KMT_ASSERT_NEXT(a_adv_fills_out, s1_adv, out_valid_r, "result register not loaded")
  `KMT_ASSERT_SAME(a_stall_means_full, !in_ch.ready, s1_valid_r && out_valid_r,
                   "bad input stall")
  `KMT_ASSERT_SAME(a_drop_is_empty, out_valid_r && (out_res_r.route == ROUTE_DROP),
                   (out_res_r.out_type == '0) && (out_res_r.out_code == '0)
                   && (out_res_r.out_value == '0), "dropped result carries an event")
  `KMT_ASSERT_SAME(a_speed_nonzero, out_valid_r, out_res_r.speed_now != '0,
                   "speed reported as zero")

endmodule
